>>> hdl/esd_pkg.sv
// Package for the escape sequence decoder.
// Holds the decode mode type, character codes, item and result types, hex helper.
// No dependencies.
package esd_pkg;

  localparam int CharW = 16;
  localparam int PosW = 16;
  localparam int MaxCharsDefault = 65535;
  localparam int DigitW = 3;

  localparam logic [CharW-1:0] ChBslash = 16'h005C;
  localparam logic [CharW-1:0] ChA = 16'h0061;
  localparam logic [CharW-1:0] ChB = 16'h0062;
  localparam logic [CharW-1:0] ChF = 16'h0066;
  localparam logic [CharW-1:0] ChN = 16'h006E;
  localparam logic [CharW-1:0] ChR = 16'h0072;
  localparam logic [CharW-1:0] ChT = 16'h0074;
  localparam logic [CharW-1:0] ChV = 16'h0076;
  localparam logic [CharW-1:0] ChX = 16'h0078;
  localparam logic [CharW-1:0] ChU = 16'h0075;

  localparam logic [CharW-1:0] CodeBel = 16'd7;
  localparam logic [CharW-1:0] CodeBs = 16'd8;
  localparam logic [CharW-1:0] CodeTab = 16'd9;
  localparam logic [CharW-1:0] CodeLf = 16'd10;
  localparam logic [CharW-1:0] CodeVt = 16'd11;
  localparam logic [CharW-1:0] CodeFf = 16'd12;
  localparam logic [CharW-1:0] CodeCr = 16'd13;

  localparam logic [DigitW-1:0] DigitsX = 3'd2;
  localparam logic [DigitW-1:0] DigitsU = 3'd4;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_FAILED = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_last;
  } item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             is_error;
    logic [PosW-1:0]  error_index;
    logic             is_last;
  } result_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 16'h0030 && c <= 16'h0039) v = {1'b0, c[3:0]};
    else if (c >= 16'h0061 && c <= 16'h0066) v = {1'b0, c[3:0] + 4'd9};
    else if (c >= 16'h0041 && c <= 16'h0046) v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

>>> hdl/escape_sequence_decoder.sv
// Each character passes through the input register and then the result register.
// Throughput: one character per cycle while the output is not stalled; the decode state updates in a single pass.
// Characters that complete nothing produce no result request.
// Reset (rst, synchronous, active high) empties both registers and returns to normal mode.
// Top level of the escape sequence decoder; depends on esd_pkg and esd_core.
module escape_sequence_decoder import esd_pkg::*; #(
  parameter int MAX_CHARS = MaxCharsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // in_char
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_char [15:0], error_index [31:16]
  output logic        m_tuser,   // is_error
  output logic        m_tlast    // is_last
);

  logic    in_valid;
  item_t   in_item;
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_res;

  assign out_free = !out_valid || m_tready;
  assign step = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.in_char <= s_tdata;
      in_item.in_last <= s_tlast;
    end
  end

  esd_core #(
    .MAX_CHARS(MAX_CHARS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {out_res.error_index, out_res.out_char};
  assign m_tuser = out_res.is_error;
  assign m_tlast = out_res.is_last;

endmodule

>>> hdl/esd_core.sv
// Decode state and next-state logic for the escape sequence decoder.
// Consumes one registered character per step and produces at most one result.
// Depends on esd_pkg.
module esd_core import esd_pkg::*; #(
  parameter int MAX_CHARS = MaxCharsDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  localparam logic [PosW:0] MaxPos = (PosW+1)'(MAX_CHARS);

  mode_t            mode, mode_next;
  logic [DigitW-1:0] digits, digits_next;
  logic [CharW-1:0] acc, acc_next;
  logic [PosW-1:0]  pos, pos_next;
  logic [PosW-1:0]  fail, fail_next;

  logic [PosW:0]    pos_wide;
  logic [PosW-1:0]  pos_inc;
  logic [4:0]       hex;
  logic [CharW-1:0] acc_shift;
  logic [CharW-1:0] mapped;

  always_comb begin
    pos_wide = {1'b0, pos} + 1'b1;
    pos_inc = (pos_wide > MaxPos) ? MaxPos[PosW-1:0] : pos_wide[PosW-1:0];
    hex = hex_value(item.in_char);
    acc_shift = {acc[CharW-5:0], hex[3:0]};
    case (item.in_char)
      ChA: mapped = CodeBel;
      ChB: mapped = CodeBs;
      ChF: mapped = CodeFf;
      ChN: mapped = CodeLf;
      ChR: mapped = CodeCr;
      ChT: mapped = CodeTab;
      ChV: mapped = CodeVt;
      default: mapped = item.in_char;
    endcase
  end

  always_comb begin
    mode_next = mode;
    digits_next = digits;
    acc_next = acc;
    fail_next = fail;
    res_valid = 1'b0;
    res = '0;
    res.is_last = item.in_last;
    case (mode)
      MODE_NORMAL: begin
        if (item.in_char == ChBslash) begin
          if (item.in_last) begin
            fail_next = pos_inc;
            mode_next = MODE_FAILED;
            res_valid = 1'b1;
            res.is_error = 1'b1;
            res.error_index = pos_inc;
          end else begin
            mode_next = MODE_ESCAPE;
          end
        end else begin
          res_valid = 1'b1;
          res.out_char = item.in_char;
        end
      end
      MODE_ESCAPE: begin
        if (item.in_char == ChX || item.in_char == ChU) begin
          mode_next = MODE_HEX;
          digits_next = (item.in_char == ChX) ? DigitsX : DigitsU;
          acc_next = '0;
          fail_next = pos_inc;
          if (item.in_last) begin
            mode_next = MODE_FAILED;
            res_valid = 1'b1;
            res.is_error = 1'b1;
            res.error_index = pos_inc;
          end
        end else begin
          mode_next = MODE_NORMAL;
          res_valid = 1'b1;
          res.out_char = mapped;
        end
      end
      MODE_HEX: begin
        if (hex[4]) begin
          mode_next = MODE_FAILED;
          if (item.in_last) begin
            res_valid = 1'b1;
            res.is_error = 1'b1;
            res.error_index = fail;
          end
        end else begin
          acc_next = acc_shift;
          if (digits <= DigitW'(1)) begin
            digits_next = '0;
            mode_next = MODE_NORMAL;
            res_valid = 1'b1;
            res.out_char = acc_shift;
          end else begin
            digits_next = digits - 1'b1;
            if (item.in_last) begin
              mode_next = MODE_FAILED;
              res_valid = 1'b1;
              res.is_error = 1'b1;
              res.error_index = fail;
            end
          end
        end
      end
      default: begin
        if (item.in_last) begin
          res_valid = 1'b1;
          res.is_error = 1'b1;
          res.error_index = fail;
        end
      end
    endcase
    pos_next = pos_inc;
    if (item.in_last) begin
      mode_next = MODE_NORMAL;
      digits_next = '0;
      acc_next = '0;
      pos_next = '0;
      fail_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      digits <= '0;
      acc <= '0;
      pos <= '0;
      fail <= '0;
    end else if (step) begin
      mode <= mode_next;
      digits <= digits_next;
      acc <= acc_next;
      pos <= pos_next;
      fail <= fail_next;
    end
  end

endmodule

>>> hdl/esd_checker.sv
// Port-level checks for the escape sequence decoder.
// Bound to escape_sequence_decoder; depends on nothing else.
module esd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result request changed while stalled");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata[15:0] == 16'd0)
    else $error("error result not final or carries a character");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'd0)
    else $error("error index set on a normal result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result request right after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> tb/tb_top.sv
// Testbench for escape_sequence_decoder: directed strings, output stalls, error positions
// and random escaped strings, checked against a cycle-free decoding predictor.
// Depends on esd_pkg and the escape_sequence_decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import esd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandomItems = 960;
  localparam logic [PosW-1:0] PosMax = PosW'(MaxCharsDefault);
  localparam logic [CharW-1:0] ChZero = 16'h0030;
  localparam logic [CharW-1:0] ChNine = 16'h0039;
  localparam logic [CharW-1:0] ChLowA = 16'h0061;
  localparam logic [CharW-1:0] ChLowF = 16'h0066;
  localparam logic [CharW-1:0] ChUpA = 16'h0041;
  localparam logic [CharW-1:0] ChUpF = 16'h0046;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  mode_t              esc_mode;
  logic [DigitW-1:0]  hex_left;
  logic [CharW-1:0]   code_acc;
  logic [PosW-1:0]    char_pos;
  logic [PosW-1:0]    fail_pos;
  result_t            decoded_q[$];
  logic [CharW-1:0]   text_q[$];
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 hold_cycles = 0;
  int                 rx_stall = 0;
  bit                 steady = 1'b0;

  escape_sequence_decoder DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #5ns;
    clk = 1'b1;
    #5ns;
  end

  function automatic logic [PosW-1:0] pos_after(input logic [PosW-1:0] p);
    return (p >= PosMax) ? PosMax : p + 1'b1;
  endfunction

  function automatic void clear_decoder();
    esc_mode = MODE_NORMAL;
    hex_left = '0;
    code_acc = '0;
    char_pos = '0;
    fail_pos = '0;
  endfunction

  function automatic void predict_char(input logic [CharW-1:0] c, input logic l);
    result_t r;
    logic [4:0] d;
    logic [PosW-1:0] here;
    bit hit;
    bit fail_now;
    here = char_pos;
    hit = 1'b0;
    fail_now = 1'b0;
    r = '0;
    case (esc_mode)
      MODE_NORMAL: begin
        if (c == ChBslash) begin
          if (l) begin
            fail_pos = pos_after(here);
            esc_mode = MODE_FAILED;
            fail_now = 1'b1;
          end else begin
            esc_mode = MODE_ESCAPE;
          end
        end else begin
          hit = 1'b1;
          r.out_char = c;
          r.is_last = l;
        end
      end
      MODE_ESCAPE: begin
        if (c == ChX || c == ChU) begin
          esc_mode = MODE_HEX;
          hex_left = (c == ChX) ? DigitsX : DigitsU;
          code_acc = '0;
          fail_pos = pos_after(here);
          if (l) begin
            esc_mode = MODE_FAILED;
            fail_now = 1'b1;
          end
        end else begin
          case (c)
            ChA: r.out_char = CodeBel;
            ChB: r.out_char = CodeBs;
            ChF: r.out_char = CodeFf;
            ChN: r.out_char = CodeLf;
            ChR: r.out_char = CodeCr;
            ChT: r.out_char = CodeTab;
            ChV: r.out_char = CodeVt;
            default: r.out_char = c;
          endcase
          esc_mode = MODE_NORMAL;
          hit = 1'b1;
          r.is_last = l;
        end
      end
      MODE_HEX: begin
        d = 5'h10;
        if (c >= ChZero && c <= ChNine) d = 5'(c - ChZero);
        else if (c >= ChLowA && c <= ChLowF) d = 5'(c - ChLowA + 10);
        else if (c >= ChUpA && c <= ChUpF) d = 5'(c - ChUpA + 10);
        if (d[4]) begin
          esc_mode = MODE_FAILED;
          fail_now = l;
        end else begin
          code_acc = {code_acc[CharW-5:0], d[3:0]};
          if (hex_left <= 1) begin
            hex_left = '0;
            esc_mode = MODE_NORMAL;
            hit = 1'b1;
            r.out_char = code_acc;
            r.is_last = l;
          end else begin
            hex_left = hex_left - 1'b1;
            if (l) begin
              esc_mode = MODE_FAILED;
              fail_now = 1'b1;
            end
          end
        end
      end
      default: fail_now = l;
    endcase
    if (fail_now) begin
      hit = 1'b1;
      r.out_char = '0;
      r.is_error = 1'b1;
      r.error_index = fail_pos;
      r.is_last = 1'b1;
    end
    char_pos = pos_after(here);
    if (hit) decoded_q.push_back(r);
    if (l) clear_decoder();
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      clear_decoder();
    end else begin
      if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.out_char = m_tdata[15:0];
        got.error_index = m_tdata[31:16];
        got.is_error = m_tuser;
        got.is_last = m_tlast;
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_char %h is_error %b", got.out_char, got.is_error);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, got.out_char);
            mismatch_count++;
          end
          if (got.is_error !== want.is_error) begin
            $error("is_error: expected %b, got %b", want.is_error, got.is_error);
            mismatch_count++;
          end
          if (got.error_index !== want.error_index) begin
            $error("error_index: expected %0d, got %0d", want.error_index, got.error_index);
            mismatch_count++;
          end
          if (got.is_last !== want.is_last) begin
            $error("is_last: expected %b, got %b", want.is_last, got.is_last);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("escape_sequence_decoder verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    int roll;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_stall = (roll < 93) ? $urandom_range(0, 2) : $urandom_range(14, 49);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [CharW-1:0] c, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= c;
    s_tlast <= l;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_request(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    wait (decoded_q.size() == 0);
    @(negedge clk);
  endtask

  function automatic logic [CharW-1:0] rand_hex_digit();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return ChZero + CharW'(v);
    if (v < 16) return ChLowA + CharW'(v - 10);
    return ChUpA + CharW'(v - 16);
  endfunction

  function automatic logic [CharW-1:0] rand_bad_digit();
    case ($urandom_range(0, 7))
      0: return ChZero - 1'b1;
      1: return ChNine + 1'b1;
      2: return ChUpA - 1'b1;
      3: return ChUpF + 1'b1;
      4: return ChLowA - 1'b1;
      5: return ChLowF + 1'b1;
      6: return 16'h0100 | CharW'($urandom_range(16'h30, 16'h66));
      default: return CharW'($urandom_range(16'h0067, 16'hFFFF));
    endcase
  endfunction

  task automatic test_directed_strings();
    // plain extremes, then \n \t and an escaped ordinary letter
    text_q = {16'h0000, 16'hFFFF, ChBslash, ChN, ChBslash, ChT, ChBslash, 16'h0071};
    send_text();
    text_q = {ChBslash, ChX, 16'h0034, ChUpF, ChBslash, ChU, ChLowA, 16'h0042, ChNine, 16'h0063};
    send_text();
    // bad digit whose low bits look like hex, then a unit after the failure
    text_q = {ChBslash, ChX, 16'h0141, ChUpA};
    send_text();
    text_q = {ChBslash, ChU, 16'h0031};
    send_text();
    text_q = {ChBslash};
    send_text();
    wait_drained();
  endtask

  task automatic test_output_stall();
    steady = 1'b1;
    hold_cycles = 300;
    text_q = {};
    repeat (40) text_q.push_back(CharW'($urandom_range(0, 16'hFFFF)));
    send_text();
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_error_position();
    steady = 1'b1;
    text_q = {};
    repeat (60) text_q.push_back(CharW'($urandom_range(16'h20, 16'h5B)));
    text_q.push_back(ChBslash);
    text_q.push_back(ChU);
    text_q.push_back(ChUpF + 1'b1);
    text_q.push_back(ChUpA);
    send_text();
    text_q = {};
    repeat (61) text_q.push_back(CharW'($urandom_range(16'h5D, 16'hFFFF)));
    text_q.push_back(ChBslash);
    send_text();
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_random_strings();
    logic [CharW-1:0] simple_esc[7];
    int sent;
    int strings;
    int pieces;
    int roll;
    int bad;
    bit cut;
    simple_esc = '{ChA, ChB, ChF, ChN, ChR, ChT, ChV};
    sent = 0;
    strings = 0;
    while (sent < RandomItems) begin
      if (strings % 25 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 4) wait_drained();
      text_q = {};
      cut = 1'b0;
      pieces = $urandom_range(1, 6);
      for (int p = 0; p < pieces && !cut; p++) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          text_q.push_back(CharW'($urandom_range(0, 16'hFFFF)));
        end else if (roll < 40) begin
          text_q.push_back(CharW'($urandom_range(16'h20, 16'h7E)));
        end else if (roll < 60) begin
          text_q.push_back(ChBslash);
          text_q.push_back(simple_esc[$urandom_range(0, 6)]);
        end else if (roll < 68) begin
          text_q.push_back(ChBslash);
          text_q.push_back(CharW'($urandom_range(0, 16'hFFFF)));
        end else if (roll < 96) begin
          text_q.push_back(ChBslash);
          text_q.push_back((roll < 80 || (roll >= 92 && roll[0])) ? ChX : ChU);
          bad = (roll >= 92) ? $urandom_range(0, 3) : -1;
          for (int k = 0; k < ((text_q[$] == ChX) ? 2 : 4); k++)
            text_q.push_back((k == bad || (bad > 1 && k == 1)) ? rand_bad_digit() :
                             rand_hex_digit());
        end else begin
          text_q.push_back(ChBslash);
          cut = 1'b1;
        end
      end
      if (!cut && text_q.size() > 1 && $urandom_range(0, 99) < 8)
        text_q = text_q[0:$urandom_range(0, text_q.size() - 2)];
      sent += text_q.size();
      strings++;
      send_text();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_strings();
    test_output_stall();
    test_error_position();
    test_random_strings();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("escape_sequence_decoder verification clean");
    end else begin
      $display("escape_sequence_decoder verification failed");
    end
    $finish;
  end

endmodule
